### rtl/core/pfe_pkg.sv
// Playfair encryptor package: letter codes, mode codes and the command and
// status structs exchanged by the controller and the datapath.
// No dependencies.
package pfe_pkg;

   localparam int LETTER_W    = 5;
   localparam int NUM_LETTERS = 26;
   localparam int NUM_CELLS   = 25;
   localparam int SIDE        = 5;
   localparam int COORD_W     = 3;

   typedef logic [LETTER_W-1:0]    letter_type;
   typedef logic [1:0]             mode_type;
   typedef logic [COORD_W-1:0]     coord_type;
   typedef logic [2*COORD_W-1:0]   pos_type;
   typedef logic [NUM_LETTERS-1:0] used_type;

   localparam mode_type MODE_KEY   = 2'd0;
   localparam mode_type MODE_MSG   = 2'd1;
   localparam mode_type MODE_END   = 2'd2;
   localparam mode_type MODE_CLEAR = 2'd3;

   localparam letter_type LET_I    = 5'd8;
   localparam letter_type LET_J    = 5'd9;
   localparam letter_type LET_X    = 5'd23;
   localparam letter_type LET_LAST = 5'd25;

   typedef struct packed {
      logic clear;
      logic key_place;
      logic fill_start;
      logic fill_step;
      logic fill_done;
      logic msg_pair;
      logic msg_latched;
      logic flush;
      logic pos_read;
      logic cell_read;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic letter_ok;
      logic key_new;
      logic square_complete;
      logic pending_valid;
      logic fill_last;
      logic rsp_stall;
   } status_type;

endpackage

### rtl/core/pfe_req_if.sv
// Request channel of the Playfair encryptor: valid/ready plus mode and letter.
// Depends on pfe_pkg.
interface pfe_req_if;
   import pfe_pkg::*;

   logic       valid;
   logic       ready;
   mode_type   mode;
   letter_type letter;

   modport source (output valid, output mode, output letter, input ready);
   modport sink   (input valid, input mode, input letter, output ready);
endinterface

### rtl/core/pfe_rsp_if.sv
// Response channel of the Playfair encryptor: valid/ready plus one enciphered
// pair with its padded plaintext. Depends on pfe_pkg.
interface pfe_rsp_if;
   import pfe_pkg::*;

   logic       valid;
   logic       ready;
   letter_type plain_first;
   letter_type plain_second;
   letter_type cipher_first;
   letter_type cipher_second;

   modport source (output valid, output plain_first, output plain_second,
                   output cipher_first, output cipher_second, input ready);
   modport sink   (input valid, input plain_first, input plain_second,
                   input cipher_first, input cipher_second, output ready);
endinterface

### rtl/core/playfair_encryptor.sv
// Playfair encryptor top level. Key, clear, ignored and unpaired letters leave
// the block ready for the next request; a request that closes a pair steps
// through the position read, square read and emit states, holding in emit
// while an earlier response is stalled, and no new request is taken until the
// response register loads. The first message letter on an incomplete square
// adds an alphabet walk. Reset clears control state only; RAMs need no clearing.
module playfair_encryptor (
   input logic      clock,
   input logic      reset,
   pfe_req_if.sink  req_bus,
   pfe_rsp_if.source rsp_bus
);
   import pfe_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       ready;

   pfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_mode  (req_bus.mode),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   pfe_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_letter        (req_bus.letter),
      .cmd               (cmd),
      .status            (status),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_bus.valid),
      .rsp_plain_first   (rsp_bus.plain_first),
      .rsp_plain_second  (rsp_bus.plain_second),
      .rsp_cipher_first  (rsp_bus.cipher_first),
      .rsp_cipher_second (rsp_bus.cipher_second)
   );

   assign req_bus.ready = ready;

   a_fill_only_incomplete: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_step |-> !status.square_complete)
      else $error("square fill walk running on a complete square");

   a_fill_done_completes: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_done |=> status.square_complete)
      else $error("square not marked complete after fill walk");

   a_flush_drops_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> !status.pending_valid)
      else $error("pending letter still valid after end of message");
endmodule

### rtl/core/pfe_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module pfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]                           rd_data_a,
   output logic [WIDTH-1:0]                           rd_data_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;
endmodule

### rtl/core/pfe_ctrl.sv
// Playfair encryptor controller: request decode, square-fill walk and the
// lookup/emit sequence. Depends on pfe_pkg.
module pfe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  pfe_pkg::mode_type    req_mode,
   output logic                 req_ready,
   input  pfe_pkg::status_type  status,
   output pfe_pkg::cmd_type     cmd
);
   import pfe_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_FILL = 3'd1;
   localparam logic [2:0] ST_POS  = 3'd2;
   localparam logic [2:0] ST_CELL = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  MODE_END: begin
                     if (status.pending_valid) begin
                        cmd.flush = 1'b1;
                        state_in  = ST_POS;
                     end
                  end
                  MODE_KEY: begin
                     cmd.key_place = status.key_new;
                  end
                  MODE_MSG: begin
                     if (status.letter_ok) begin
                        if (status.square_complete) begin
                           cmd.msg_pair = 1'b1;
                           if (status.pending_valid) begin
                              state_in = ST_POS;
                           end
                        end else begin
                           cmd.fill_start = 1'b1;
                           state_in       = ST_FILL;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               cmd.fill_done   = 1'b1;
               cmd.msg_pair    = 1'b1;
               cmd.msg_latched = 1'b1;
               state_in        = status.pending_valid ? ST_POS : ST_IDLE;
            end
         end
         ST_POS: begin
            cmd.pos_read = 1'b1;
            state_in     = ST_CELL;
         end
         ST_CELL: begin
            cmd.cell_read = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (!status.rsp_stall) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

### rtl/core/pfe_datapath.sv
// Playfair encryptor datapath: square and letter-position RAMs, fill counters,
// pending letter, pair rules and the response register.
// Depends on pfe_pkg and pfe_ram.
module pfe_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  pfe_pkg::letter_type  req_letter,
   input  pfe_pkg::cmd_type     cmd,
   output pfe_pkg::status_type  status,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output pfe_pkg::letter_type  rsp_plain_first,
   output pfe_pkg::letter_type  rsp_plain_second,
   output pfe_pkg::letter_type  rsp_cipher_first,
   output pfe_pkg::letter_type  rsp_cipher_second
);
   import pfe_pkg::*;

   function automatic coord_type coord_inc(input coord_type v);
      return (v == coord_type'(SIDE - 1)) ? '0 : v + coord_type'(1);
   endfunction

   function automatic letter_type cell_addr(input coord_type r, input coord_type c);
      return letter_type'(int'(r) * SIDE + int'(c));
   endfunction

   // control state
   used_type   used_ff, used_in;
   letter_type count_ff, count_in;
   coord_type  row_ff, row_in;
   coord_type  col_ff, col_in;
   logic       complete_ff, complete_in;
   logic       pvalid_ff, pvalid_in;
   letter_type pending_ff, pending_in;
   letter_type walk_ff, walk_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // payload
   letter_type latched_ff;
   letter_type p1_ff, p1_in;
   letter_type p2_ff, p2_in;
   letter_type plain1_ff, plain2_ff, cipher1_ff, cipher2_ff;

   letter_type norm_letter;
   letter_type msg_letter;
   letter_type place_letter;
   logic       letter_ok;
   logic       fill_write;
   logic       wr_en;
   logic       pend_match;
   pos_type    q1, q2;
   coord_type  r1, c1, r2, c2;
   letter_type a1, a2;
   letter_type e1, e2;

   assign norm_letter  = (req_letter == LET_J) ? LET_I : req_letter;
   assign letter_ok    = (req_letter < letter_type'(NUM_LETTERS));
   assign msg_letter   = cmd.msg_latched ? latched_ff : norm_letter;
   assign pend_match   = (pending_ff == msg_letter);
   assign fill_write   = cmd.fill_step & (walk_ff != LET_J) & ~used_ff[walk_ff]
                         & (count_ff < letter_type'(NUM_CELLS));
   assign place_letter = cmd.fill_step ? walk_ff : norm_letter;
   assign wr_en        = cmd.key_place | fill_write;

   always_comb begin
      used_in      = used_ff;
      count_in     = count_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      complete_in  = complete_ff;
      pvalid_in    = pvalid_ff;
      pending_in   = pending_ff;
      walk_in      = walk_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      rsp_valid_in = rsp_valid_ff;

      if (wr_en) begin
         used_in  = used_in | (used_type'(1) << place_letter);
         count_in = count_ff + letter_type'(1);
         col_in   = coord_inc(col_ff);
         if (col_ff == coord_type'(SIDE - 1)) begin
            row_in = coord_inc(row_ff);
         end
      end
      if ((cmd.key_place && place_letter == LET_I) || cmd.fill_done) begin
         used_in = used_in | (used_type'(1) << LET_J);
      end
      if (cmd.fill_done) begin
         complete_in = 1'b1;
      end
      if (cmd.fill_start) begin
         walk_in = '0;
      end else if (cmd.fill_step) begin
         walk_in = walk_ff + letter_type'(1);
      end

      if (cmd.msg_pair) begin
         if (!pvalid_ff) begin
            pending_in = msg_letter;
            pvalid_in  = 1'b1;
         end else begin
            p1_in     = pending_ff;
            p2_in     = pend_match ? LET_X : msg_letter;
            pvalid_in = pend_match;
         end
      end
      if (cmd.flush) begin
         p1_in     = pending_ff;
         p2_in     = LET_X;
         pvalid_in = 1'b0;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.clear) begin
         used_in     = '0;
         count_in    = '0;
         row_in      = '0;
         col_in      = '0;
         complete_in = 1'b0;
         pvalid_in   = 1'b0;
         pending_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         count_ff     <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         complete_ff  <= 1'b0;
         pvalid_ff    <= 1'b0;
         pending_ff   <= '0;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         count_ff     <= count_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         complete_ff  <= complete_in;
         pvalid_ff    <= pvalid_in;
         pending_ff   <= pending_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fill_start) begin
         latched_ff <= norm_letter;
      end
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      if (cmd.emit) begin
         plain1_ff  <= p1_ff;
         plain2_ff  <= p2_ff;
         cipher1_ff <= e1;
         cipher2_ff <= e2;
      end
   end

   // letter -> {row, col}
   pfe_ram #(
      .WIDTH (2 * COORD_W),
      .DEPTH (NUM_LETTERS)
   ) u_pos_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (place_letter),
      .wr_data   ({row_ff, col_ff}),
      .rd_en     (cmd.pos_read),
      .rd_addr_a (p1_ff),
      .rd_addr_b (p2_ff),
      .rd_data_a (q1),
      .rd_data_b (q2)
   );

   assign r1 = q1[2*COORD_W-1:COORD_W];
   assign c1 = q1[COORD_W-1:0];
   assign r2 = q2[2*COORD_W-1:COORD_W];
   assign c2 = q2[COORD_W-1:0];

   always_comb begin
      if (r1 == r2) begin
         a1 = cell_addr(r1, coord_inc(c1));
         a2 = cell_addr(r1, coord_inc(c2));
      end else if (c1 == c2) begin
         a1 = cell_addr(coord_inc(r1), c1);
         a2 = cell_addr(coord_inc(r2), c1);
      end else begin
         a1 = cell_addr(r1, c2);
         a2 = cell_addr(r2, c1);
      end
   end

   // cell -> letter
   pfe_ram #(
      .WIDTH (LETTER_W),
      .DEPTH (NUM_CELLS)
   ) u_square_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (count_ff),
      .wr_data   (place_letter),
      .rd_en     (cmd.cell_read),
      .rd_addr_a (a1),
      .rd_addr_b (a2),
      .rd_data_a (e1),
      .rd_data_b (e2)
   );

   assign status.letter_ok       = letter_ok;
   assign status.key_new         = letter_ok & ~complete_ff & ~used_ff[norm_letter];
   assign status.square_complete = complete_ff;
   assign status.pending_valid   = pvalid_ff;
   assign status.fill_last       = (walk_ff == LET_LAST);
   assign status.rsp_stall       = rsp_valid_ff & ~rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_plain_first   = plain1_ff;
   assign rsp_plain_second  = plain2_ff;
   assign rsp_cipher_first  = cipher1_ff;
   assign rsp_cipher_second = cipher2_ff;
endmodule

### tb/playfair_pair_checker.sv
`timescale 1ns / 100ps
// Watches the request and response channels of playfair_encryptor, predicts
// each enciphered pair from the accepted requests and compares field by field.
// Depends on pfe_pkg, pfe_req_if and pfe_rsp_if.
module playfair_pair_checker (
   input  logic clock,
   input  logic reset,
   pfe_req_if   req_bus,
   pfe_rsp_if   rsp_bus,
   output int   mismatches,
   output int   pairs_waiting,
   output int   pairs_checked,
   output int   row_pairs,
   output int   column_pairs,
   output int   rect_pairs
);
   import pfe_pkg::*;

   typedef struct packed {
      letter_type plain_first;
      letter_type plain_second;
      letter_type cipher_first;
      letter_type cipher_second;
   } cipher_pair_type;

   letter_type      square [NUM_CELLS];
   int              cell_of [NUM_LETTERS];
   used_type        taken;
   int              placed;
   logic            sealed;
   letter_type      held;
   logic            held_valid;
   cipher_pair_type expected_pairs [$];

   int errors_seen;
   int checked_seen;
   int row_seen;
   int column_seen;
   int rect_seen;

   task automatic wipe_square();
      taken      = '0;
      placed     = 0;
      sealed     = 1'b0;
      held       = '0;
      held_valid = 1'b0;
   endtask

   task automatic append_letter(input letter_type l);
      if (placed < NUM_CELLS) begin
         square[placed] = l;
         cell_of[l]     = placed;
         placed++;
         taken[l]       = 1'b1;
      end
   endtask

   task automatic seal_square();
      for (int h = 0; h < NUM_LETTERS; h++) begin
         if (h != LET_J && !taken[h])
            append_letter(letter_type'(h));
      end
      taken[LET_J] = 1'b1;
      sealed       = 1'b1;
   endtask

   function automatic cipher_pair_type encipher_pair(input letter_type a, input letter_type b);
      cipher_pair_type pair;
      int r1, c1, r2, c2;
      r1 = cell_of[a] / SIDE;
      c1 = cell_of[a] % SIDE;
      r2 = cell_of[b] / SIDE;
      c2 = cell_of[b] % SIDE;
      pair.plain_first  = a;
      pair.plain_second = b;
      if (r1 == r2) begin
         pair.cipher_first  = square[r1 * SIDE + (c1 + 1) % SIDE];
         pair.cipher_second = square[r1 * SIDE + (c2 + 1) % SIDE];
         row_seen++;
      end else if (c1 == c2) begin
         pair.cipher_first  = square[((r1 + 1) % SIDE) * SIDE + c1];
         pair.cipher_second = square[((r2 + 1) % SIDE) * SIDE + c1];
         column_seen++;
      end else begin
         pair.cipher_first  = square[r1 * SIDE + c2];
         pair.cipher_second = square[r2 * SIDE + c1];
         rect_seen++;
      end
      return pair;
   endfunction

   task automatic predict_request(input mode_type m, input letter_type l);
      letter_type lt;
      lt = (l == LET_J) ? LET_I : l;
      case (m)
         MODE_CLEAR: begin
            wipe_square();
         end
         MODE_END: begin
            if (held_valid) begin
               held_valid = 1'b0;
               expected_pairs.push_back(encipher_pair(held, LET_X));
            end
         end
         MODE_KEY: begin
            if (lt <= LET_LAST && !sealed && !taken[lt]) begin
               append_letter(lt);
               if (lt == LET_I)
                  taken[LET_J] = 1'b1;
            end
         end
         default: begin
            if (lt <= LET_LAST) begin
               if (!sealed)
                  seal_square();
               if (!held_valid) begin
                  held       = lt;
                  held_valid = 1'b1;
               end else if (held == lt) begin
                  expected_pairs.push_back(encipher_pair(held, LET_X));
               end else begin
                  expected_pairs.push_back(encipher_pair(held, lt));
                  held_valid = 1'b0;
               end
            end
         end
      endcase
   endtask

   task automatic check_field(input string name, input letter_type want, input letter_type got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors_seen++;
      end
   endtask

   task automatic compare_pair(input cipher_pair_type got);
      cipher_pair_type want;
      if (expected_pairs.size() == 0) begin
         $error("unexpected response: plain %0d %0d cipher %0d %0d", got.plain_first,
                got.plain_second, got.cipher_first, got.cipher_second);
         errors_seen++;
         return;
      end
      want = expected_pairs.pop_front();
      check_field("plain_first", want.plain_first, got.plain_first);
      check_field("plain_second", want.plain_second, got.plain_second);
      check_field("cipher_first", want.cipher_first, got.cipher_first);
      check_field("cipher_second", want.cipher_second, got.cipher_second);
      checked_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         wipe_square();
         expected_pairs.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            compare_pair({rsp_bus.plain_first, rsp_bus.plain_second,
                          rsp_bus.cipher_first, rsp_bus.cipher_second});
         if (req_bus.valid && req_bus.ready)
            predict_request(req_bus.mode, req_bus.letter);
      end
      mismatches    <= errors_seen;
      pairs_waiting <= expected_pairs.size();
      pairs_checked <= checked_seen;
      row_pairs     <= row_seen;
      column_pairs  <= column_seen;
      rect_pairs    <= rect_seen;
   end

endmodule

### tb/playfair_encryptor_test.sv
`timescale 1ns / 100ps
// Top of the playfair_encryptor testbench: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on pfe_pkg, the channel
// interfaces, playfair_encryptor and playfair_pair_checker.
module playfair_encryptor_test;
   import pfe_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int idle_pct;
   int stall_pct;
   int requests_sent;
   int mismatches;
   int pairs_waiting;
   int pairs_checked;
   int row_pairs;
   int column_pairs;
   int rect_pairs;

   pfe_req_if req_bus();
   pfe_rsp_if rsp_bus();

   playfair_encryptor dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   playfair_pair_checker cipher_check (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .mismatches    (mismatches),
      .pairs_waiting (pairs_waiting),
      .pairs_checked (pairs_checked),
      .row_pairs     (row_pairs),
      .column_pairs  (column_pairs),
      .rect_pairs    (rect_pairs)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   task automatic send_request(input mode_type m, input letter_type l);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.mode   <= m;
      req_bus.letter <= l;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (m == MODE_END || m == MODE_CLEAR || l <= LET_LAST)
         requests_sent++;
   endtask

   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pairs_waiting != 0)
         @(posedge clock);
   endtask

   // key phase, message phase and end of message, with some noise mixed in
   task automatic run_session();
      int keys;
      int msgs;
      letter_type prev;
      letter_type pick;
      if ($urandom_range(3) != 0)
         send_request(MODE_CLEAR, letter_type'($urandom_range(31)));
      keys = ($urandom_range(9) == 0) ? 30 : $urandom_range(12);
      repeat (keys)
         send_request(MODE_KEY, ($urandom_range(19) == 0) ? letter_type'($urandom_range(31))
                                                          : letter_type'($urandom_range(25)));
      msgs = $urandom_range(16, 1);
      prev = letter_type'($urandom_range(25));
      repeat (msgs) begin
         if ($urandom_range(19) == 0)
            send_request(mode_type'($urandom_range(3)), letter_type'($urandom_range(31)));
         case ($urandom_range(9))
            0, 1:    pick = prev;
            2:       pick = LET_X;
            default: pick = letter_type'($urandom_range(25));
         endcase
         send_request(MODE_MSG, pick);
         prev = pick;
      end
      if ($urandom_range(4) != 0)
         send_request(MODE_END, letter_type'($urandom_range(31)));
   endtask

   initial begin
      int idle_by_phase [4];
      int stall_by_phase [4];
      int goal;
      int drain_cycles;
      idle_by_phase  = '{0, 50, 0, 21};
      stall_by_phase = '{0, 0, 50, 21};
      idle_pct       = 0;
      stall_pct      = 0;
      requests_sent  = 0;
      req_bus.valid  <= 1'b0;
      req_bus.mode   <= MODE_KEY;
      req_bus.letter <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // blank square, extremes, doubled pairs, ignored letters
      send_request(MODE_END, 5'd31);
      send_request(MODE_MSG, 5'd0);
      send_request(MODE_MSG, LET_LAST);
      send_request(MODE_MSG, LET_J);
      send_request(MODE_MSG, LET_I);
      send_request(MODE_KEY, 5'd3);
      send_request(MODE_MSG, 5'd30);
      send_request(MODE_END, 5'd0);
      send_request(MODE_CLEAR, 5'd31);
      // keyed square with duplicates and I/J merge
      send_request(MODE_KEY, 5'd15);
      send_request(MODE_KEY, 5'd11);
      send_request(MODE_KEY, 5'd0);
      send_request(MODE_KEY, 5'd24);
      send_request(MODE_KEY, 5'd5);
      send_request(MODE_KEY, LET_J);
      send_request(MODE_KEY, LET_I);
      send_request(MODE_KEY, 5'd0);
      send_request(MODE_KEY, 5'd31);
      send_request(MODE_KEY, 5'd17);
      send_request(MODE_MSG, LET_X);
      send_request(MODE_MSG, LET_X);
      send_request(MODE_END, 5'd12);
      send_request(MODE_MSG, 5'd4);
      send_request(MODE_CLEAR, 5'd0);
      hold_until_drained();

      goal = requests_sent;
      for (int p = 0; p < 4; p++) begin
         idle_pct  = idle_by_phase[p];
         stall_pct = stall_by_phase[p];
         goal      = goal + 100;
         while (requests_sent < goal)
            run_session();
         hold_until_drained();
      end

      idle_pct  = 0;
      stall_pct = 0;
      for (drain_cycles = 0; drain_cycles < 5000 && pairs_waiting != 0; drain_cycles++)
         @(posedge clock);
      repeat (12) @(posedge clock);
      if (pairs_waiting != 0)
         $error("%0d expected pairs never arrived", pairs_waiting);

      $display("%0d requests sent over four pacing phases, %0d enciphered pairs checked",
               requests_sent, pairs_checked);
      $display("pairs by rule: %0d same row, %0d same column, %0d rectangle",
               row_pairs, column_pairs, rect_pairs);
      if (mismatches == 0 && pairs_waiting == 0)
         $display("playfair_encryptor regression: pass");
      else
         $display("playfair_encryptor regression: fail");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("playfair_encryptor regression: fail");
      $finish;
   end

endmodule
